// ----- hw/rtl/plid_pkg.sv -----
// Shared types, constants and helpers for the positional list block.
// Used by plid_cell, plid_chain and positional_list_insert_delete; no dependencies.
package plid_pkg;

  localparam int CAPACITY  = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int ENTRY_W   = 32;
  localparam int POS_W     = 8;
  localparam int OUT_CNT_W = 6;
  localparam int CMP_W     = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic signed [ENTRY_W-1:0] entry_t;
  typedef logic [CNT_W-1:0]          count_t;
  typedef logic [IDX_W-1:0]          index_t;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_LIST   = 2'd2;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_BADPOS = 2'd1;
  localparam logic [1:0] STATUS_FULL   = 2'd2;
  localparam logic [1:0] STATUS_EMPTY  = 2'd3;

  // Operation broadcast along the chain.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_ROTATE = 2'd3
  } chain_op_t;

  // Source that one cell loads in the next cycle.
  typedef enum logic [2:0] {
    SEL_HOLD = 3'd0,
    SEL_LOAD = 3'd1,
    SEL_LO   = 3'd2,
    SEL_HI   = 3'd3,
    SEL_HEAD = 3'd4
  } cell_sel_t;

  typedef struct packed {
    chain_op_t op;
    index_t    pos;
    count_t    total;
  } chain_ctrl_t;

  // Fits a count into the 6-bit result field, padding or masking as needed.
  function automatic logic [OUT_CNT_W-1:0] to_count_field(input count_t c);
    logic [CNT_W+OUT_CNT_W-1:0] wide;
    wide = {{OUT_CNT_W{1'b0}}, c};
    return wide[OUT_CNT_W-1:0];
  endfunction

endpackage

// ----- hw/rtl/positional_list_insert_delete.sv -----
// Top level of the bounded positional list: command port, sequencer and cell chain.
// Depends on plid_pkg and plid_chain.
module positional_list_insert_delete (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_kind,
  input  logic signed [7:0]     in_position,
  input  logic signed [31:0]    in_item_value,
  output logic                  out_valid,
  output logic [1:0]            out_status,
  output logic signed [31:0]    out_entry_value,
  output logic [5:0]            out_entry_count,
  output logic                  out_last
);
  import plid_pkg::*;

  // The list is held in a row of CAPACITY cells. An insert or delete shifts
  // every affected cell in the cycle the item is accepted, so insert, delete,
  // a rejected item and a list request on an empty list all leave busy low and
  // give their single result, marked by out_valid, in the next cycle. A list
  // request on a list of N entries rotates the occupied cells one step per
  // cycle: busy stays high while the sequencer is in the list state, and the
  // N results follow one per cycle, each registered from the head cell as the
  // list state steps, with out_last on the final one. After N steps the
  // rotation has returned every entry to its place. The result port has no
  // backpressure: a result is on the ports for exactly one cycle and must be
  // taken then. An item with kind 3 is accepted and dropped with no result.

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LIST = 2'b10
  } state_t;

  state_t      state_r, state_nxt;
  count_t      total_r, total_nxt;
  count_t      idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_status_r, out_status_nxt;
  entry_t      out_value_r, out_value_nxt;
  logic [5:0]  out_count_r, out_count_nxt;
  logic        out_last_r, out_last_nxt;

  chain_ctrl_t ctrl;
  entry_t      head;

  logic             accept;
  logic             pos_neg;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] tot_ext;
  logic             list_last;

  assign accept    = start && (state_r == ST_IDLE);
  assign pos_neg   = in_position[POS_W-1];
  assign pos_ext   = CMP_W'(in_position[POS_W-2:0]);
  assign tot_ext   = CMP_W'(total_r);
  assign list_last = ((idx_r + CNT_W'(1)) == total_r);

  always_comb begin
    state_nxt      = state_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = STATUS_OK;
    out_value_nxt  = '0;
    out_count_nxt  = to_count_field(total_r);
    out_last_nxt   = 1'b1;
    ctrl.op        = OP_HOLD;
    ctrl.pos       = in_position[IDX_W-1:0];
    ctrl.total     = total_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_INSERT: begin
              out_valid_nxt = 1'b1;
              if (pos_neg || pos_ext > tot_ext) begin
                out_status_nxt = STATUS_BADPOS;
              end else if (total_r == count_t'(CAPACITY)) begin
                out_status_nxt = STATUS_FULL;
              end else begin
                ctrl.op       = OP_INSERT;
                total_nxt     = total_r + CNT_W'(1);
                out_count_nxt = to_count_field(total_nxt);
              end
            end
            KIND_DELETE: begin
              out_valid_nxt = 1'b1;
              if (pos_neg || pos_ext >= tot_ext) begin
                out_status_nxt = STATUS_BADPOS;
              end else begin
                ctrl.op       = OP_DELETE;
                total_nxt     = total_r - CNT_W'(1);
                out_count_nxt = to_count_field(total_nxt);
              end
            end
            KIND_LIST: begin
              if (total_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STATUS_EMPTY;
              end else begin
                state_nxt = ST_LIST;
                idx_nxt   = '0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_LIST: begin
        // Emit the head entry and rotate the occupied cells by one.
        ctrl.op       = OP_ROTATE;
        out_valid_nxt = 1'b1;
        out_value_nxt = head;
        out_last_nxt  = list_last;
        idx_nxt       = idx_r + CNT_W'(1);
        if (list_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      total_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  plid_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .load_val (in_item_value),
    .head     (head)
  );

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_entry_value = out_value_r;
  assign out_entry_count = out_count_r;
  assign out_last        = out_last_r;

endmodule

// ----- hw/rtl/plid_cell.sv -----
// One storage cell of the list chain: a 32-bit entry and its input selector.
// Depends on plid_pkg.
module plid_cell (
  input  logic                clk,
  input  plid_pkg::cell_sel_t sel,
  input  plid_pkg::entry_t    load_val,
  input  plid_pkg::entry_t    lo_val,
  input  plid_pkg::entry_t    hi_val,
  input  plid_pkg::entry_t    head_val,
  output plid_pkg::entry_t    data
);
  import plid_pkg::*;

  entry_t data_r;
  entry_t data_nxt;

  always_comb begin
    case (sel)
      SEL_LOAD: data_nxt = load_val;
      SEL_LO:   data_nxt = lo_val;
      SEL_HI:   data_nxt = hi_val;
      SEL_HEAD: data_nxt = head_val;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

// ----- hw/rtl/plid_chain.sv -----
// Row of CAPACITY list cells with per-cell source selection.
// Depends on plid_pkg and plid_cell.
module plid_chain (
  input  logic                  clk,
  input  plid_pkg::chain_ctrl_t ctrl,
  input  plid_pkg::entry_t      load_val,
  output plid_pkg::entry_t      head
);
  import plid_pkg::*;

  entry_t data [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam index_t MY_IDX  = IDX_W'(i);
    localparam count_t NEXT_CT = CNT_W'(i + 1);

    cell_sel_t sel;
    entry_t    lo_val;
    entry_t    hi_val;

    if (i == 0) begin : g_first
      assign lo_val = '0;
    end else begin : g_mid_lo
      assign lo_val = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign hi_val = data[i];
    end else begin : g_mid_hi
      assign hi_val = data[i+1];
    end

    always_comb begin
      sel = SEL_HOLD;
      case (ctrl.op)
        OP_INSERT: begin
          if (MY_IDX == ctrl.pos) begin
            sel = SEL_LOAD;
          end else if (MY_IDX > ctrl.pos) begin
            sel = SEL_LO;
          end
        end
        OP_DELETE: begin
          if (MY_IDX >= ctrl.pos && i != CAPACITY - 1) begin
            sel = SEL_HI;
          end
        end
        OP_ROTATE: begin
          // Entries below the tail move toward the head; the tail takes the head.
          if (NEXT_CT < ctrl.total) begin
            sel = SEL_HI;
          end else if (NEXT_CT == ctrl.total) begin
            sel = SEL_HEAD;
          end
        end
        default: sel = SEL_HOLD;
      endcase
    end

    plid_cell u_cell (
      .clk      (clk),
      .sel      (sel),
      .load_val (load_val),
      .lo_val   (lo_val),
      .hi_val   (hi_val),
      .head_val (data[0]),
      .data     (data[i])
    );
  end

  assign head = data[0];

endmodule
